// ===== hdl/mesh_vertex_dedup_indexer_top_macros.svh =====
// Assertion macros for the mesh vertex dedup indexer.
// Included by the top module, which carries the concurrent checks.
`ifndef MESH_VERTEX_DEDUP_INDEXER_TOP_MACROS_SVH
`define MESH_VERTEX_DEDUP_INDEXER_TOP_MACROS_SVH
`ifndef SYNTH
`define MVD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m: lbl");
`define MVD_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: lbl");
`else
`define MVD_ASSERT(lbl, clk, rstn, prop)
`define MVD_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== hdl/mvdi_pkg.sv =====
// Package for the mesh vertex dedup indexer: widths, codes, types.
// No dependencies.
package mvdi_pkg;
  localparam int unsigned AttrDepthDef = 1024;
  localparam int unsigned VertDepthDef = 1024;
  localparam int unsigned WordW  = 32;
  localparam int unsigned IdxW   = 16;
  localparam int unsigned KeyW   = 48;
  localparam int unsigned OutIdxW = 10;

  typedef enum logic [1:0] {
    MODE_POS  = 2'd0,
    MODE_TEX  = 2'd1,
    MODE_NRM  = 2'd2,
    MODE_FACE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_READ,
    ST_OUT
  } state_e;

  // Search control that enters the head of the cell chain
  typedef struct packed {
    logic            start;
    logic [KeyW-1:0] key;
  } srch_t;
endpackage

// ===== hdl/mvdi_if.sv =====
// Valid/ready channel interfaces for input items and results.
// Depends on mvdi_pkg.
interface mvdi_in_if;
  import mvdi_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [WordW-1:0]  word_a;
  logic [WordW-1:0]  word_b;
  logic [WordW-1:0]  word_c;
  logic signed [IdxW-1:0] vert_idx;
  logic signed [IdxW-1:0] tex_idx;
  logic signed [IdxW-1:0] norm_idx;
  modport source (output valid, mode, word_a, word_b, word_c, vert_idx, tex_idx,
                  norm_idx, input ready);
  modport sink (input valid, mode, word_a, word_b, word_c, vert_idx, tex_idx,
                norm_idx, output ready);
endinterface

interface mvdi_out_if;
  import mvdi_pkg::*;
  logic               valid;
  logic               ready;
  logic [OutIdxW-1:0] vertex_index;
  logic               is_new;
  logic               overflow;
  logic [WordW-1:0]   out_pos_x;
  logic [WordW-1:0]   out_pos_y;
  logic [WordW-1:0]   out_pos_z;
  logic [WordW-1:0]   out_tex_u;
  logic [WordW-1:0]   out_tex_v;
  logic [WordW-1:0]   out_nrm_x;
  logic [WordW-1:0]   out_nrm_y;
  logic [WordW-1:0]   out_nrm_z;
  modport source (output valid, vertex_index, is_new, overflow, out_pos_x, out_pos_y,
                  out_pos_z, out_tex_u, out_tex_v, out_nrm_x, out_nrm_y, out_nrm_z,
                  input ready);
  modport sink (input valid, vertex_index, is_new, overflow, out_pos_x, out_pos_y,
                out_pos_z, out_tex_u, out_tex_v, out_nrm_x, out_nrm_y, out_nrm_z,
                output ready);
endinterface

// ===== hdl/mvdi_cell.sv =====
// One key cell of the systolic dedup chain: holds one vertex key and
// compares the search key passing by. Depends on mvdi_pkg.
module mvdi_cell import mvdi_pkg::*; #(
  parameter int unsigned VertDepth = VertDepthDef,
  parameter int unsigned Index     = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_i,      // write key into this cell
  input  logic [KeyW-1:0]              wr_key_i,
  input  logic [$clog2(VertDepth+1)-1:0] count_i,
  input  srch_t                        srch_i,    // search token from left
  input  logic                         hit_i,     // hit found upstream
  input  logic [$clog2(VertDepth)-1:0] hit_idx_i,
  output srch_t                        srch_o,
  output logic                         hit_o,
  output logic [$clog2(VertDepth)-1:0] hit_idx_o
);
  localparam int unsigned IW = $clog2(VertDepth);
  localparam int unsigned CW = $clog2(VertDepth+1);

  logic [KeyW-1:0] key_q;
  logic            start_q;
  logic [KeyW-1:0] skey_q;
  logic            hit_q;
  logic [IW-1:0]   hit_idx_q;
  logic            match;

  // key storage, written once when the vertex is appended
  always_ff @(posedge clk_i) begin
    if (wr_i) key_q <= wr_key_i;
  end

  // compare only if this cell holds a live key; first hit wins
  assign match = srch_i.start && !hit_i && (CW'(Index) < count_i) &&
                 (key_q == srch_i.key);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      start_q <= srch_i.start;
      hit_q   <= srch_i.start && (hit_i || match);
    end
  end

  always_ff @(posedge clk_i) begin
    skey_q    <= srch_i.key;
    hit_idx_q <= match ? IW'(Index) : hit_idx_i;
  end

  assign srch_o    = {start_q, skey_q};
  assign hit_o     = hit_q;
  assign hit_idx_o = hit_idx_q;
endmodule

// ===== hdl/mvdi_attr_mem.sv =====
// Attribute store: append-only RAM with a saturating fill count and a
// registered read port. Depends on mvdi_pkg.
module mvdi_attr_mem import mvdi_pkg::*; #(
  parameter int unsigned Depth = AttrDepthDef,
  parameter int unsigned Width = 3*WordW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_i,
  input  logic [Width-1:0]              wr_data_i,
  input  logic                          rd_i,
  input  logic [IdxW-1:0]               rd_idx_i,   // one-based signed index
  output logic [Width-1:0]              rd_data_o   // zero when out of range
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth+1);

  logic [Width-1:0] mem [Depth];
  logic [CW-1:0]    count_q;
  logic [Width-1:0] rd_q;
  logic             ok_q;
  logic             ok;
  logic [IdxW-1:0]  slot;

  // fill count saturates at depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else if (wr_i && count_q < CW'(Depth)) count_q <= count_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && count_q < CW'(Depth)) mem[count_q[AW-1:0]] <= wr_data_i;
  end

  // range check: positive and not above the count
  assign slot = rd_idx_i - 1'b1;
  assign ok = !rd_idx_i[IdxW-1] && (rd_idx_i != '0) &&
              ({{(IdxW+1){1'b0}}, count_q} > {{(CW+1){1'b0}}, slot});

  always_ff @(posedge clk_i) begin
    if (rd_i) begin
      rd_q <= mem[slot[AW-1:0]];
      ok_q <= ok;
    end
  end

  assign rd_data_o = ok_q ? rd_q : '0;
endmodule

// ===== hdl/mesh_vertex_dedup_indexer_top.sv =====
// Mesh vertex dedup indexer: a face corner is searched by a token walking the key
// cell chain one cell per cycle, then passes a decide, a registered attribute
// read and an output cycle. Attribute records go straight to the output state
// with no search. The result sits in an output register; the next item is
// taken once the previous result has been transferred. No clearing pass.
// Depends on mvdi_pkg, mvdi_if, mvdi_cell, mvdi_attr_mem and the macro header.
`include "mesh_vertex_dedup_indexer_top_macros.svh"
module mesh_vertex_dedup_indexer_top import mvdi_pkg::*; #(
  parameter int unsigned AttrDepth = AttrDepthDef,
  parameter int unsigned VertDepth = VertDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mvdi_in_if.sink    in_i,
  mvdi_out_if.source out_o
);
  localparam int unsigned IW = $clog2(VertDepth);
  localparam int unsigned CW = $clog2(VertDepth+1);

  state_e state_q, state_d;
  logic [1:0]         mode_q;
  logic [KeyW-1:0]    key_q;
  logic [CW-1:0]      uniq_q;
  logic [CW-1:0]      cnt_q;   // cycles in search
  logic               acc;

  // chain wiring
  srch_t          srch [VertDepth+1];
  logic           hit  [VertDepth+1];
  logic [IW-1:0]  hidx [VertDepth+1];

  logic                 new_q, ovf_q, ovl_q, ins;
  logic [IW-1:0]        vidx_q;
  logic                 ovalid_q;
  logic [3*WordW-1:0]   pos_rd, nrm_rd;
  logic [2*WordW-1:0]   tex_rd;
  logic                 rd_en;

  assign in_i.ready = (state_q == ST_IDLE) && !ovalid_q;
  assign acc = in_i.valid && in_i.ready;

  // state register and item latches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      uniq_q  <= '0;
      cnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SEARCH) cnt_q <= cnt_q + 1'b1;
      else cnt_q <= '0;
      if (ins) uniq_q <= uniq_q + 1'b1;
      if (state_q == ST_OUT) ovalid_q <= (mode_q == MODE_FACE);
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mode_q <= in_i.mode;
      key_q  <= {in_i.vert_idx, in_i.tex_idx, in_i.norm_idx};
    end
    if (state_q == ST_DECIDE) begin
      new_q  <= !hit[VertDepth] && (uniq_q < CW'(VertDepth));
      ovf_q  <= !hit[VertDepth] && !(uniq_q < CW'(VertDepth));
      vidx_q <= hit[VertDepth] ? hidx[VertDepth] :
                (uniq_q < CW'(VertDepth) ? uniq_q[IW-1:0] : '0);
    end
  end

  // next state; the token reaches the chain end in the decide cycle
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (acc) state_d = (in_i.mode == MODE_FACE) ? ST_SEARCH : ST_OUT;
      ST_SEARCH: if (cnt_q == CW'(VertDepth - 1)) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_READ;
      ST_READ:   state_d = ST_OUT;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // attribute record leaves no result; ovl_q tracks a real face result
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT) ovl_q <= (mode_q == MODE_FACE);
  end

  assign ins   = (state_q == ST_DECIDE) && !hit[VertDepth] && (uniq_q < CW'(VertDepth));
  assign rd_en = (state_q == ST_DECIDE);

  // key cell chain
  assign srch[0].start = (state_q == ST_SEARCH) && (cnt_q == '0);
  assign srch[0].key   = key_q;
  assign hit[0]  = 1'b0;
  assign hidx[0] = '0;
  for (genvar g = 0; g < VertDepth; g++) begin : g_cell
    mvdi_cell #(.VertDepth(VertDepth), .Index(g)) u_cell (
      .clk_i, .rst_ni,
      .wr_i(ins && (uniq_q[IW-1:0] == IW'(g))),
      .wr_key_i(key_q),
      .count_i(uniq_q),
      .srch_i(srch[g]), .hit_i(hit[g]), .hit_idx_i(hidx[g]),
      .srch_o(srch[g+1]), .hit_o(hit[g+1]), .hit_idx_o(hidx[g+1])
    );
  end

  // attribute stores
  mvdi_attr_mem #(.Depth(AttrDepth), .Width(3*WordW)) u_pos (
    .clk_i, .rst_ni,
    .wr_i(acc && in_i.mode == MODE_POS),
    .wr_data_i({in_i.word_a, in_i.word_b, in_i.word_c}),
    .rd_i(rd_en), .rd_idx_i(key_q[3*IdxW-1:2*IdxW]), .rd_data_o(pos_rd));
  mvdi_attr_mem #(.Depth(AttrDepth), .Width(2*WordW)) u_tex (
    .clk_i, .rst_ni,
    .wr_i(acc && in_i.mode == MODE_TEX),
    .wr_data_i({in_i.word_a, in_i.word_b}),
    .rd_i(rd_en), .rd_idx_i(key_q[2*IdxW-1:IdxW]), .rd_data_o(tex_rd));
  mvdi_attr_mem #(.Depth(AttrDepth), .Width(3*WordW)) u_nrm (
    .clk_i, .rst_ni,
    .wr_i(acc && in_i.mode == MODE_NRM),
    .wr_data_i({in_i.word_a, in_i.word_b, in_i.word_c}),
    .rd_i(rd_en), .rd_idx_i(key_q[IdxW-1:0]), .rd_data_o(nrm_rd));

  // output register
  logic [OutIdxW-1:0] oidx_q;
  logic               onew_q, oovf_q;
  logic [3*WordW-1:0] opos_q, onrm_q;
  logic [2*WordW-1:0] otex_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      oidx_q <= OutIdxW'({{OutIdxW{1'b0}}, vidx_q});
      onew_q <= new_q;
      oovf_q <= ovf_q;
      opos_q <= new_q ? pos_rd : '0;
      otex_q <= new_q ? tex_rd : '0;
      onrm_q <= new_q ? nrm_rd : '0;
    end
  end

  assign out_o.valid        = ovalid_q && ovl_q;
  assign out_o.vertex_index = oidx_q;
  assign out_o.is_new       = onew_q;
  assign out_o.overflow     = oovf_q;
  assign out_o.out_pos_x    = opos_q[3*WordW-1:2*WordW];
  assign out_o.out_pos_y    = opos_q[2*WordW-1:WordW];
  assign out_o.out_pos_z    = opos_q[WordW-1:0];
  assign out_o.out_tex_u    = otex_q[2*WordW-1:WordW];
  assign out_o.out_tex_v    = otex_q[WordW-1:0];
  assign out_o.out_nrm_x    = onrm_q[3*WordW-1:2*WordW];
  assign out_o.out_nrm_y    = onrm_q[2*WordW-1:WordW];
  assign out_o.out_nrm_z    = onrm_q[WordW-1:0];

  `MVD_ASSERT(a_no_hit_new, clk_i, rst_ni, out_o.valid |-> !(out_o.is_new && out_o.overflow))
  `MVD_ASSERT(a_uniq_bound, clk_i, rst_ni, uniq_q <= CW'(VertDepth))
  `MVD_ASSERT(a_ins_once, clk_i, rst_ni, ins |=> !ins)
endmodule

// ===== tb/mesh_vertex_dedup_indexer_top_tb.sv =====
// Testbench for mesh_vertex_dedup_indexer_top: a queue-fed driver and a monitor
// check every result against an in-bench predictor of the vertex dedup logic.
// Depends on mvdi_pkg, mvdi_if and the RTL of the block.
`timescale 1ns / 1ps
module mesh_vertex_dedup_indexer_top_tb;
  import mvdi_pkg::*;

  localparam int unsigned AttrDepth = AttrDepthDef;
  localparam int unsigned VertDepth = VertDepthDef;

  typedef struct {
    mode_e       mode;
    bit [31:0]   wa, wb, wc;
    bit [15:0]   vi, ti, ni;
  } mesh_item_t;

  typedef struct {
    bit [9:0]  vidx;
    bit        is_new;
    bit        ovf;
    bit [31:0] w [8];
  } corner_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mvdi_in_if  in_if ();
  mvdi_out_if out_if ();

  mesh_vertex_dedup_indexer_top #(
    .AttrDepth(AttrDepth),
    .VertDepth(VertDepth)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  bit [31:0] pos_mem [AttrDepth][3];
  bit [31:0] tex_mem [AttrDepth][2];
  bit [31:0] nrm_mem [AttrDepth][3];
  int unsigned pos_cnt, tex_cnt, nrm_cnt, vert_cnt;
  bit [47:0] vert_keys [VertDepth];

  mesh_item_t  pending_q [$];
  corner_res_t corner_q [$];
  mesh_item_t  cur_item;

  int unsigned err_cnt, corners_seen, hits_seen, new_seen, ovf_seen, dropped_recs;
  bit          no_idle;

  // Generator-side view, used to steer indices and key reuse
  int unsigned gen_cnt [3];
  bit [47:0]   gen_keys [$];
  bit          gen_keyset [bit [47:0]];

  task automatic report_mismatch(string what, longint got, longint want);
    err_cnt++;
    $display("%0t ERROR %s: got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic bit slot_ok(bit [15:0] raw, int unsigned cnt, output int unsigned slot);
    slot = 0;
    if (raw == 16'd0 || raw[15]) return 1'b0;
    if (raw - 1 >= cnt) return 1'b0;
    slot = raw - 1;
    return 1'b1;
  endfunction

  // Applies one accepted item to the predictor, queuing the corner result if any
  task automatic apply_item(mesh_item_t it);
    corner_res_t r;
    bit [47:0]   key;
    int unsigned s;
    bit          hit;
    r.vidx = '0; r.is_new = 1'b0; r.ovf = 1'b0;
    foreach (r.w[k]) r.w[k] = '0;
    hit = 1'b0;
    case (it.mode)
      MODE_POS: begin
        if (pos_cnt < AttrDepth) begin
          pos_mem[pos_cnt] = '{it.wa, it.wb, it.wc};
          pos_cnt++;
        end else dropped_recs++;
      end
      MODE_TEX: begin
        if (tex_cnt < AttrDepth) begin
          tex_mem[tex_cnt] = '{it.wa, it.wb};
          tex_cnt++;
        end else dropped_recs++;
      end
      MODE_NRM: begin
        if (nrm_cnt < AttrDepth) begin
          nrm_mem[nrm_cnt] = '{it.wa, it.wb, it.wc};
          nrm_cnt++;
        end else dropped_recs++;
      end
      default: begin
        key = {it.vi, it.ti, it.ni};
        for (int i = 0; i < vert_cnt; i++) begin
          if (!hit && vert_keys[i] == key) begin
            hit = 1'b1;
            r.vidx = i[9:0];
          end
        end
        if (!hit && vert_cnt >= VertDepth) begin
          r.ovf = 1'b1;
        end else if (!hit) begin
          vert_keys[vert_cnt] = key;
          r.vidx = vert_cnt[9:0];
          r.is_new = 1'b1;
          if (slot_ok(it.vi, pos_cnt, s)) begin
            r.w[0] = pos_mem[s][0]; r.w[1] = pos_mem[s][1]; r.w[2] = pos_mem[s][2];
          end
          if (slot_ok(it.ti, tex_cnt, s)) begin
            r.w[3] = tex_mem[s][0]; r.w[4] = tex_mem[s][1];
          end
          if (slot_ok(it.ni, nrm_cnt, s)) begin
            r.w[5] = nrm_mem[s][0]; r.w[6] = nrm_mem[s][1]; r.w[7] = nrm_mem[s][2];
          end
          vert_cnt++;
        end
        corner_q = {corner_q, r};
      end
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: one transfer per handshake, random gaps between items
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) apply_item(cur_item);
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          in_if.mode     <= cur_item.mode;
          in_if.word_a   <= cur_item.wa;
          in_if.word_b   <= cur_item.wb;
          in_if.word_c   <= cur_item.wc;
          in_if.vert_idx <= cur_item.vi;
          in_if.tex_idx  <= cur_item.ti;
          in_if.norm_idx <= cur_item.ni;
          in_if.valid    <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compares each result with the oldest expectation
  int unsigned out_stall;
  always @(posedge clk_i or negedge rst_ni) begin
    corner_res_t e;
    bit [31:0]   got_w [8];
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_w = '{out_if.out_pos_x, out_if.out_pos_y, out_if.out_pos_z, out_if.out_tex_u,
                  out_if.out_tex_v, out_if.out_nrm_x, out_if.out_nrm_y, out_if.out_nrm_z};
        if (corner_q.size() == 0) begin
          report_mismatch("result with nothing expected, vertex_index",
                          out_if.vertex_index, 0);
        end else begin
          e = corner_q.pop_front();
          corners_seen++;
          if (e.ovf) ovf_seen++;
          else if (e.is_new) new_seen++;
          else hits_seen++;
          if (out_if.vertex_index !== e.vidx)
            report_mismatch("vertex_index", out_if.vertex_index, e.vidx);
          if (out_if.is_new !== e.is_new) report_mismatch("is_new", out_if.is_new, e.is_new);
          if (out_if.overflow !== e.ovf) report_mismatch("overflow", out_if.overflow, e.ovf);
          foreach (got_w[k])
            if (got_w[k] !== e.w[k])
              report_mismatch($sformatf("attribute word %0d", k), got_w[k], e.w[k]);
        end
        out_stall = pick_gap();
      end
      if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus helpers
  task automatic push_rec(mode_e m, bit [31:0] a, bit [31:0] b, bit [31:0] c);
    mesh_item_t it;
    it = '{m, a, b, c, 16'($urandom()), 16'($urandom()), 16'($urandom())};
    pending_q = {pending_q, it};
    if (gen_cnt[m] < AttrDepth) gen_cnt[m]++;
  endtask

  task automatic push_corner(bit [15:0] vi, bit [15:0] ti, bit [15:0] ni);
    mesh_item_t it;
    bit [47:0]  key;
    key = {vi, ti, ni};
    it = '{MODE_FACE, $urandom(), $urandom(), $urandom(), vi, ti, ni};
    pending_q = {pending_q, it};
    if (!gen_keyset.exists(key)) begin
      gen_keyset[key] = 1'b1;
      gen_keys = {gen_keys, key};
    end
  endtask

  function automatic bit [15:0] pick_idx(int unsigned cnt);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(1, (cnt == 0) ? 1 : cnt));
    if (r < 84) return 16'd0;
    if (r < 88) return 16'(cnt + 1);
    if (r < 92) return 16'h8000 | 16'($urandom());
    return 16'($urandom());
  endfunction

  task automatic push_random_corner(int unsigned new_pct);
    bit [47:0] key;
    if (gen_keys.size() > 0 && $urandom_range(0, 99) >= new_pct) begin
      key = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
      push_corner(key[47:32], key[31:16], key[15:0]);
    end else begin
      do begin
        key = {pick_idx(gen_cnt[MODE_POS]), pick_idx(gen_cnt[MODE_TEX]),
               pick_idx(gen_cnt[MODE_NRM])};
      end while (gen_keyset.exists(key));
      push_corner(key[47:32], key[31:16], key[15:0]);
    end
  endtask

  task automatic push_random_rec();
    mode_e m;
    m = mode_e'($urandom_range(0, 2));
    push_rec(m, $urandom(), $urandom(), $urandom());
  endtask

  task automatic wait_drained();
    wait (pending_q.size() == 0 && !in_if.valid && corner_q.size() == 0);
    repeat (VertDepth + 20) @(posedge clk_i);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = MODE_POS;
    in_if.word_a = '0; in_if.word_b = '0; in_if.word_c = '0;
    in_if.vert_idx = '0; in_if.tex_idx = '0; in_if.norm_idx = '0;
    out_if.ready = 1'b0;
    no_idle = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners against empty stores, field extremes, hits and bad indices
    push_corner(16'd1, 16'd1, 16'd1);
    push_rec(MODE_POS, 32'h0, 32'h0, 32'h0);
    push_rec(MODE_POS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_rec(MODE_TEX, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    push_rec(MODE_NRM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h3F80_0000);
    push_rec(MODE_NRM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    push_corner(16'd1, 16'd1, 16'd1);
    push_corner(16'd2, 16'd1, 16'd2);
    push_corner(16'd2, 16'd1, 16'd2);
    push_corner(16'd0, 16'd0, 16'd0);
    push_corner(16'hFFFF, 16'h8000, 16'h7FFF);
    push_corner(16'd3, 16'd2, 16'd3);
    push_rec(MODE_TEX, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0);
    push_corner(16'd3, 16'd2, 16'd3);
    push_corner(16'd2, 16'd2, 16'd1);
    push_corner(16'h7FFF, 16'hFFFF, 16'h8000);
    push_corner(16'd1, 16'd0, 16'd2);
    push_corner(16'd1, 16'd1, 16'd1);
    wait_drained();

    // Mixed random traffic while stores are small
    for (int i = 0; i < 200; i++) begin
      no_idle = (i >= 120 && i < 180);
      if ($urandom_range(0, 99) < 40) push_random_rec();
      else push_random_corner(70);
    end

    // Mostly new corners until the vertex table fills, then hits and overflows
    while (gen_keys.size() < VertDepth + 30) begin
      if ($urandom_range(0, 99) < 3) push_random_rec();
      else push_random_corner(88);
    end
    for (int i = 0; i < 20; i++) push_random_corner(50);

    wait_drained();
    $display("Covered %0d corners: %0d new, %0d hits, %0d overflows; %0d records dropped.",
             corners_seen, new_seen, hits_seen, ovf_seen, dropped_recs);
    if (err_cnt == 0) begin
      $display("mesh_vertex_dedup_indexer_top_tb: PASS");
    end else begin
      $display("mesh_vertex_dedup_indexer_top_tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("Timeout with %0d results outstanding", corner_q.size());
    $display("mesh_vertex_dedup_indexer_top_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mvdi_pkg.sv
hdl/mvdi_if.sv
hdl/mvdi_cell.sv
hdl/mvdi_attr_mem.sv
hdl/mesh_vertex_dedup_indexer_top.sv
tb/mesh_vertex_dedup_indexer_top_tb.sv
